FILE: rtl/dctp_pkg.sv
// shared constants for the disc collision time predictor
package dctp_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int VEL_BITS_DEF = 24;
    localparam int TIME_BITS    = 40;
    localparam int TIME_FRAC    = 16;

endpackage

FILE: rtl/dctp_divider.sv
// pipelined restoring divider giving a saturated time quotient, one bit per stage
module dctp_divider #(
    parameter int NUM_W   = 8,
    parameter int DEN_W   = 8,
    parameter int NUM_SHL = 0,
    parameter int DEN_SHL = 0
) (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [NUM_W-1:0]               num,
    input  logic [DEN_W-1:0]               den,
    output logic [dctp_pkg::TIME_BITS-1:0] quot
);
    import dctp_pkg::*;

    localparam int TB = TIME_BITS;
    localparam int NW = NUM_W + NUM_SHL;
    localparam int DW = DEN_W + DEN_SHL;
    localparam int CW = ((NW > DW) ? NW : DW) + 1;

    logic [NW+TB-1:0] n_ext;
    logic [DW-1:0]    d_full;
    logic [CW-1:0]    hi_c;
    logic [CW-1:0]    d_c;
    logic             sat;

    logic [DW-1:0] rem_reg [TB+1];
    logic [DW-1:0] rem_next [TB+1];
    logic [TB-1:0] lo_reg [TB+1];
    logic [TB-1:0] lo_next [TB+1];
    logic [TB-1:0] q_reg [TB+1];
    logic [TB-1:0] q_next [TB+1];
    logic [DW-1:0] d_reg [TB+1];
    logic [DW-1:0] d_next [TB+1];
    logic          sat_reg [TB+1];
    logic          sat_next [TB+1];

    assign n_ext  = (NW + TB)'(num) << NUM_SHL;
    assign d_full = DW'(den) << DEN_SHL;
    assign hi_c   = CW'(n_ext[NW+TB-1:TB]);
    assign d_c    = CW'(d_full);
    // quotient would not fit in the time field
    assign sat    = (hi_c >= d_c);

    always_comb begin
        logic [DW:0] t;
        logic        ge;
        rem_next[0] = hi_c[DW-1:0];
        lo_next[0]  = n_ext[TB-1:0];
        q_next[0]   = '0;
        d_next[0]   = d_full;
        sat_next[0] = sat;
        for (int j = 1; j <= TB; j++) begin
            t  = {rem_reg[j-1], lo_reg[j-1][TB-j]};
            ge = (t >= {1'b0, d_reg[j-1]});
            rem_next[j] = ge ? DW'(t - {1'b0, d_reg[j-1]}) : t[DW-1:0];
            q_next[j]   = q_reg[j-1];
            q_next[j][TB-j] = ge;
            lo_next[j]  = lo_reg[j-1];
            d_next[j]   = d_reg[j-1];
            sat_next[j] = sat_reg[j-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j <= TB; j++) begin
                rem_reg[j] <= rem_next[j];
                lo_reg[j]  <= lo_next[j];
                q_reg[j]   <= q_next[j];
                d_reg[j]   <= d_next[j];
                sat_reg[j] <= sat_next[j];
            end
        end
    end

    assign quot = sat_reg[TB] ? '1 : q_reg[TB];

endmodule

FILE: rtl/disc_collision_time_predictor_unit.sv
// top level of the disc collision time predictor: pair and wall times for two discs
module disc_collision_time_predictor_unit #(
    parameter int POS_BITS = dctp_pkg::POS_BITS_DEF,
    parameter int VEL_BITS = dctp_pkg::VEL_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [POS_BITS-1:0]            s_a_pos_x,
    input  logic [POS_BITS-1:0]            s_a_pos_y,
    input  logic signed [VEL_BITS-1:0]     s_a_vel_x,
    input  logic signed [VEL_BITS-1:0]     s_a_vel_y,
    input  logic [POS_BITS-1:0]            s_a_radius,
    input  logic [POS_BITS-1:0]            s_b_pos_x,
    input  logic [POS_BITS-1:0]            s_b_pos_y,
    input  logic signed [VEL_BITS-1:0]     s_b_vel_x,
    input  logic signed [VEL_BITS-1:0]     s_b_vel_y,
    input  logic [POS_BITS-1:0]            s_b_radius,
    input  logic                           s_same_particle,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [dctp_pkg::TIME_BITS-1:0] m_pair_time,
    output logic                           m_pair_never,
    output logic [dctp_pkg::TIME_BITS-1:0] m_vwall_time,
    output logic                           m_vwall_never,
    output logic [dctp_pkg::TIME_BITS-1:0] m_hwall_time,
    output logic                           m_hwall_never
);
    // Each request carries two discs and yields one result: the time until the
    // discs touch and the times until disc A reaches a vertical and a horizontal
    // wall, all unsigned Q24.16 and saturated. A new request is taken every cycle
    // unless the pipeline stalls. The pipeline holds seven arithmetic stages
    // (difference, products, dot products, split partial products and partial sums
    // for the discriminant, discriminant), one square root stage per root bit
    // (POS_BITS + VEL_BITS + 2), a numerator stage, a prep stage plus one divider
    // stage per quotient bit (41 divider stages in all), and the output register.
    // The output register parts the two sides, so the pipeline keeps accepting
    // while a result waits, and stalls only when its last stage also holds a result.
    import dctp_pkg::*;

    localparam int P    = POS_BITS;
    localparam int V    = VEL_BITS;
    localparam int WA   = P + V + 2;          // magnitude of dv.dr
    localparam int WV   = 2 * V + 2;          // dv.dv
    localparam int WEA  = 2 * P + 2;          // magnitude of dr.dr - sigma^2
    localparam int H1   = (WA + 1) / 2;
    localparam int W_R2 = 4 * H1;
    localparam int HV   = (WV + 1) / 2;
    localparam int HE   = (WEA + 1) / 2;
    localparam int W_M  = 2 * HV + 2 * HE;
    localparam int WDD  = ((W_R2 > W_M) ? W_R2 : W_M) + 1;
    localparam int WS   = WA;                 // root bits
    localparam int WX   = 2 * WS;             // radicand bits
    localparam int K    = V + TIME_FRAC - P;
    localparam int KL   = (K >= 0) ? K : 0;
    localparam int KR   = (K < 0) ? -K : 0;
    localparam int DL   = TIME_BITS + 1;      // number of divider stages

    typedef struct packed {
        logic          never;
        logic [P:0]    num;
        logic [V-1:0]  den;
    } wall_t;

    typedef struct packed {
        logic          pok;
        logic [WA-1:0] adr;
        logic [WV-1:0] dvdv;
        wall_t         wv;
        wall_t         wh;
    } side_t;

    typedef struct packed {
        logic pnever;
        logic vnever;
        logic hnever;
    } flags_t;

    // distance to the wall ahead along one axis, the speed toward it and a never flag for zero speed
    function automatic wall_t wall_calc(input logic [P-1:0] pos, input logic [V-1:0] vel,
                                        input logic [P-1:0] rad);
        wall_t             w;
        logic signed [P+1:0] t;
        logic [V-1:0]      nv;
        nv      = -vel;
        w.never = (vel == '0);
        if (vel[V-1]) begin
            t     = $signed({2'b00, pos}) - $signed({2'b00, rad});
            w.den = nv;
        end else begin
            t     = $signed({2'b01, {P{1'b0}}}) - $signed({2'b00, pos}) - $signed({2'b00, rad});
            w.den = vel;
        end
        // at or past the wall clamps to zero time
        w.num = (t[P+1] || (t == '0)) ? '0 : t[P:0];
        return w;
    endfunction

    logic adv;
    logic out_free;
    logic last_valid;

    // stage 1: differences
    logic              s1_v_reg;
    logic signed [P:0] s1_dx_reg, s1_dy_reg;
    logic signed [V:0] s1_dvx_reg, s1_dvy_reg;
    logic [P:0]        s1_sig_reg;
    logic              s1_same_reg;
    wall_t             s1_wv_reg, s1_wh_reg;

    // stage 2: products
    logic                  s2_v_reg;
    logic signed [P+V+1:0] s2_pxv_reg, s2_pyv_reg;
    logic signed [2*V+1:0] s2_vxx_reg, s2_vyy_reg;
    logic signed [2*P+1:0] s2_xx_reg, s2_yy_reg;
    logic [2*P+1:0]        s2_ss_reg;
    logic                  s2_same_reg;
    wall_t                 s2_wv_reg, s2_wh_reg;

    // stage 3: dot products
    logic signed [WA:0]    dvdr;
    logic signed [WA:0]    ndvdr;
    logic [WV-1:0]         dvdv;
    logic [2*P+1:0]        drdr;
    logic signed [2*P+2:0] e_val;
    logic signed [2*P+2:0] ne_val;
    logic                  s3_v_reg;
    logic                  s3_cand_reg;
    logic [WA-1:0]         s3_adr_reg;
    logic [WV-1:0]         s3_dvdv_reg;
    logic                  s3_eneg_reg;
    logic [WEA-1:0]        s3_ae_reg;
    wall_t                 s3_wv_reg, s3_wh_reg;

    // stage 4: split partial products
    logic [2*H1-1:0]    a_ext;
    logic [2*HV-1:0]    b_ext;
    logic [2*HE-1:0]    c_ext;
    logic               s4_v_reg;
    logic               s4_cand_reg;
    logic [WA-1:0]      s4_adr_reg;
    logic [WV-1:0]      s4_dvdv_reg;
    logic               s4_eneg_reg;
    logic [2*H1-1:0]    s4_hh_reg, s4_lh_reg, s4_ll_reg;
    logic [HV+HE-1:0]   s4_bhch_reg, s4_blcl_reg, s4_bhcl_reg, s4_blch_reg;
    wall_t              s4_wv_reg, s4_wh_reg;

    // stage 5 and 6: partial sums
    logic               s5_v_reg;
    logic               s5_cand_reg;
    logic [WA-1:0]      s5_adr_reg;
    logic [WV-1:0]      s5_dvdv_reg;
    logic               s5_eneg_reg;
    logic [W_R2-1:0]    s5_r2_reg;
    logic [W_M-1:0]     s5_x1_reg;
    logic [HV+HE-1:0]   s5_blch_reg;
    wall_t              s5_wv_reg, s5_wh_reg;

    logic               s6_v_reg;
    logic               s6_cand_reg;
    logic [WA-1:0]      s6_adr_reg;
    logic [WV-1:0]      s6_dvdv_reg;
    logic               s6_eneg_reg;
    logic [W_R2-1:0]    s6_r2_reg;
    logic [W_M-1:0]     s6_m_reg;
    wall_t              s6_wv_reg, s6_wh_reg;

    // stage 7: discriminant
    logic signed [WDD-1:0] r2s, ms, dd;
    logic                  s7_v_reg;
    logic [WX-1:0]         s7_x_reg;
    side_t                 s7_side_reg;

    // square root stages
    logic          sq_v_reg [WS];
    logic          sq_v_next [WS];
    side_t         sq_side_reg [WS];
    side_t         sq_side_next [WS];
    logic [WX-1:0] sq_x_reg [WS];
    logic [WX-1:0] sq_x_next [WS];
    logic [WS+1:0] sq_rem_reg [WS];
    logic [WS+1:0] sq_rem_next [WS];
    logic [WS-1:0] sq_root_reg [WS];
    logic [WS-1:0] sq_root_next [WS];

    // numerator stage
    logic [WA:0]   n_diff;
    logic          sn_v_reg;
    logic          sn_pnever_reg;
    logic [WA-1:0] sn_n_reg;
    logic [WV-1:0] sn_dvdv_reg;
    wall_t         sn_wv_reg, sn_wh_reg;

    // flags riding alongside the dividers
    logic   fv_reg [DL];
    logic   fv_next [DL];
    flags_t fl_reg [DL];
    flags_t fl_next [DL];

    logic [TIME_BITS-1:0] pair_q, vwall_q, hwall_q;

    logic                 m_valid_reg;
    logic [TIME_BITS-1:0] m_pair_time_reg, m_vwall_time_reg, m_hwall_time_reg;
    logic                 m_pair_never_reg, m_vwall_never_reg, m_hwall_never_reg;

    // the pipeline moves unless its last stage and the output register are both full and m_ready is low
    assign last_valid = fv_reg[DL-1];
    assign out_free   = !m_valid_reg || m_ready;
    assign adv        = out_free || !last_valid;
    assign s_ready    = adv;

    // stage 3 arithmetic
    assign dvdr   = s2_pxv_reg + s2_pyv_reg;
    assign ndvdr  = -dvdr;
    assign dvdv   = $unsigned(s2_vxx_reg) + $unsigned(s2_vyy_reg);
    assign drdr   = $unsigned(s2_xx_reg) + $unsigned(s2_yy_reg);
    assign e_val  = $signed({1'b0, drdr}) - $signed({1'b0, s2_ss_reg});
    assign ne_val = -e_val;

    // stage 4 operand split
    assign a_ext = (2 * H1)'(s3_adr_reg);
    assign b_ext = (2 * HV)'(s3_dvdv_reg);
    assign c_ext = (2 * HE)'(s3_ae_reg);

    // stage 7: d = dvdr^2 - dvdv * e
    assign r2s = $signed(WDD'(s6_r2_reg));
    assign ms  = $signed(WDD'(s6_m_reg));
    assign dd  = s6_eneg_reg ? (r2s + ms) : (r2s - ms);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            s6_v_reg <= 1'b0;
            s7_v_reg <= 1'b0;
        end else if (adv) begin
            s1_v_reg <= s_valid;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            s6_v_reg <= s5_v_reg;
            s7_v_reg <= s6_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            // stage 1
            s1_dx_reg   <= $signed({1'b0, s_b_pos_x}) - $signed({1'b0, s_a_pos_x});
            s1_dy_reg   <= $signed({1'b0, s_b_pos_y}) - $signed({1'b0, s_a_pos_y});
            s1_dvx_reg  <= $signed({s_b_vel_x[V-1], s_b_vel_x})
                           - $signed({s_a_vel_x[V-1], s_a_vel_x});
            s1_dvy_reg  <= $signed({s_b_vel_y[V-1], s_b_vel_y})
                           - $signed({s_a_vel_y[V-1], s_a_vel_y});
            s1_sig_reg  <= {1'b0, s_a_radius} + {1'b0, s_b_radius};
            s1_same_reg <= s_same_particle;
            s1_wv_reg   <= wall_calc(s_a_pos_x, s_a_vel_x, s_a_radius);
            s1_wh_reg   <= wall_calc(s_a_pos_y, s_a_vel_y, s_a_radius);
            // stage 2
            s2_pxv_reg  <= s1_dx_reg * s1_dvx_reg;
            s2_pyv_reg  <= s1_dy_reg * s1_dvy_reg;
            s2_vxx_reg  <= s1_dvx_reg * s1_dvx_reg;
            s2_vyy_reg  <= s1_dvy_reg * s1_dvy_reg;
            s2_xx_reg   <= s1_dx_reg * s1_dx_reg;
            s2_yy_reg   <= s1_dy_reg * s1_dy_reg;
            s2_ss_reg   <= s1_sig_reg * s1_sig_reg;
            s2_same_reg <= s1_same_reg;
            s2_wv_reg   <= s1_wv_reg;
            s2_wh_reg   <= s1_wh_reg;
            // stage 3: approaching, moving relative to each other, distinct discs
            s3_cand_reg <= !s2_same_reg && (dvdr[WA] || (dvdr == '0)) && (dvdv != '0);
            s3_adr_reg  <= dvdr[WA] ? ndvdr[WA-1:0] : dvdr[WA-1:0];
            s3_dvdv_reg <= dvdv;
            s3_eneg_reg <= e_val[2*P+2];
            s3_ae_reg   <= e_val[2*P+2] ? ne_val[2*P+1:0] : e_val[2*P+1:0];
            s3_wv_reg   <= s2_wv_reg;
            s3_wh_reg   <= s2_wh_reg;
            // stage 4
            s4_cand_reg <= s3_cand_reg;
            s4_adr_reg  <= s3_adr_reg;
            s4_dvdv_reg <= s3_dvdv_reg;
            s4_eneg_reg <= s3_eneg_reg;
            s4_hh_reg   <= a_ext[2*H1-1:H1] * a_ext[2*H1-1:H1];
            s4_lh_reg   <= a_ext[H1-1:0] * a_ext[2*H1-1:H1];
            s4_ll_reg   <= a_ext[H1-1:0] * a_ext[H1-1:0];
            s4_bhch_reg <= b_ext[2*HV-1:HV] * c_ext[2*HE-1:HE];
            s4_blcl_reg <= b_ext[HV-1:0] * c_ext[HE-1:0];
            s4_bhcl_reg <= b_ext[2*HV-1:HV] * c_ext[HE-1:0];
            s4_blch_reg <= b_ext[HV-1:0] * c_ext[2*HE-1:HE];
            s4_wv_reg   <= s3_wv_reg;
            s4_wh_reg   <= s3_wh_reg;
            // stage 5
            s5_cand_reg <= s4_cand_reg;
            s5_adr_reg  <= s4_adr_reg;
            s5_dvdv_reg <= s4_dvdv_reg;
            s5_eneg_reg <= s4_eneg_reg;
            s5_r2_reg   <= {s4_hh_reg, s4_ll_reg} + (W_R2'(s4_lh_reg) << (H1 + 1));
            s5_x1_reg   <= {s4_bhch_reg, s4_blcl_reg} + (W_M'(s4_bhcl_reg) << HV);
            s5_blch_reg <= s4_blch_reg;
            s5_wv_reg   <= s4_wv_reg;
            s5_wh_reg   <= s4_wh_reg;
            // stage 6
            s6_cand_reg <= s5_cand_reg;
            s6_adr_reg  <= s5_adr_reg;
            s6_dvdv_reg <= s5_dvdv_reg;
            s6_eneg_reg <= s5_eneg_reg;
            s6_r2_reg   <= s5_r2_reg;
            s6_m_reg    <= s5_x1_reg + (W_M'(s5_blch_reg) << HE);
            s6_wv_reg   <= s5_wv_reg;
            s6_wh_reg   <= s5_wh_reg;
            // stage 7: negative discriminant means no contact
            s7_x_reg         <= dd[WX-1:0];
            s7_side_reg.pok  <= s6_cand_reg && !dd[WDD-1];
            s7_side_reg.adr  <= s6_adr_reg;
            s7_side_reg.dvdv <= s6_dvdv_reg;
            s7_side_reg.wv   <= s6_wv_reg;
            s7_side_reg.wh   <= s6_wh_reg;
        end
    end

    // square root, one root bit per stage
    always_comb begin
        logic [WS+3:0] cur;
        logic [WS+3:0] trial;
        logic [WX-1:0] xs;
        logic [WS+1:0] rs;
        logic [WS-1:0] ts;
        for (int k = 0; k < WS; k++) begin
            if (k == 0) begin
                xs              = s7_x_reg;
                rs              = '0;
                ts              = '0;
                sq_v_next[k]    = s7_v_reg;
                sq_side_next[k] = s7_side_reg;
            end else begin
                xs              = sq_x_reg[k-1];
                rs              = sq_rem_reg[k-1];
                ts              = sq_root_reg[k-1];
                sq_v_next[k]    = sq_v_reg[k-1];
                sq_side_next[k] = sq_side_reg[k-1];
            end
            cur   = {rs, xs[WX-1-2*k -: 2]};
            trial = (WS + 4)'({ts, 2'b01});
            if (cur >= trial) begin
                sq_rem_next[k]  = (WS + 2)'(cur - trial);
                sq_root_next[k] = {ts[WS-2:0], 1'b1};
            end else begin
                sq_rem_next[k]  = cur[WS+1:0];
                sq_root_next[k] = {ts[WS-2:0], 1'b0};
            end
            sq_x_next[k] = xs;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < WS; k++) begin
                sq_v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 0; k < WS; k++) begin
                sq_v_reg[k] <= sq_v_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < WS; k++) begin
                sq_side_reg[k] <= sq_side_next[k];
                sq_x_reg[k]    <= sq_x_next[k];
                sq_rem_reg[k]  <= sq_rem_next[k];
                sq_root_reg[k] <= sq_root_next[k];
            end
        end
    end

    // numerator -dvdr - sqrt(d), overlapping discs clamp to zero
    assign n_diff = {1'b0, sq_side_reg[WS-1].adr} - {1'b0, sq_root_reg[WS-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sn_v_reg <= 1'b0;
        end else if (adv) begin
            sn_v_reg <= sq_v_reg[WS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sn_pnever_reg <= !sq_side_reg[WS-1].pok;
            sn_n_reg      <= n_diff[WA] ? '0 : n_diff[WA-1:0];
            sn_dvdv_reg   <= sq_side_reg[WS-1].dvdv;
            sn_wv_reg     <= sq_side_reg[WS-1].wv;
            sn_wh_reg     <= sq_side_reg[WS-1].wh;
        end
    end

    dctp_divider #(
        .NUM_W   (WA),
        .DEN_W   (WV),
        .NUM_SHL (KL),
        .DEN_SHL (P + KR - P)
    ) u_pair_div (
        .aclk (aclk),
        .en   (adv),
        .num  (sn_n_reg),
        .den  (sn_dvdv_reg),
        .quot (pair_q)
    );

    dctp_divider #(
        .NUM_W   (P + 1),
        .DEN_W   (V),
        .NUM_SHL (KL),
        .DEN_SHL (KR)
    ) u_vwall_div (
        .aclk (aclk),
        .en   (adv),
        .num  (sn_wv_reg.num),
        .den  (sn_wv_reg.den),
        .quot (vwall_q)
    );

    dctp_divider #(
        .NUM_W   (P + 1),
        .DEN_W   (V),
        .NUM_SHL (KL),
        .DEN_SHL (KR)
    ) u_hwall_div (
        .aclk (aclk),
        .en   (adv),
        .num  (sn_wh_reg.num),
        .den  (sn_wh_reg.den),
        .quot (hwall_q)
    );

    // never flags delayed to line up with the quotients
    always_comb begin
        for (int j = 0; j < DL; j++) begin
            if (j == 0) begin
                fv_next[j]        = sn_v_reg;
                fl_next[j].pnever = sn_pnever_reg;
                fl_next[j].vnever = sn_wv_reg.never;
                fl_next[j].hnever = sn_wh_reg.never;
            end else begin
                fv_next[j] = fv_reg[j-1];
                fl_next[j] = fl_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < DL; j++) begin
                fv_reg[j] <= 1'b0;
            end
        end else if (adv) begin
            for (int j = 0; j < DL; j++) begin
                fv_reg[j] <= fv_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < DL; j++) begin
                fl_reg[j] <= fl_next[j];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_pair_time_reg   <= fl_reg[DL-1].pnever ? '1 : pair_q;
            m_pair_never_reg  <= fl_reg[DL-1].pnever;
            m_vwall_time_reg  <= fl_reg[DL-1].vnever ? '1 : vwall_q;
            m_vwall_never_reg <= fl_reg[DL-1].vnever;
            m_hwall_time_reg  <= fl_reg[DL-1].hnever ? '1 : hwall_q;
            m_hwall_never_reg <= fl_reg[DL-1].hnever;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pair_time   = m_pair_time_reg;
    assign m_pair_never  = m_pair_never_reg;
    assign m_vwall_time  = m_vwall_time_reg;
    assign m_vwall_never = m_vwall_never_reg;
    assign m_hwall_time  = m_hwall_time_reg;
    assign m_hwall_never = m_hwall_never_reg;

    // an accepted request always lands in the first stage
    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> s1_v_reg)
        else $error("accepted request lost at pipeline entry");

    // a stall only happens with a result parked in the last stage, and it stays there
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> last_valid)
        else $error("last stage emptied during a stall");

    // a waiting result is not dropped
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result dropped while waiting");

    // never results carry an all ones time
    a_never_ones: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_pair_never || m_vwall_never || m_hwall_never)) |->
        ((!m_pair_never || (m_pair_time == '1)) && (!m_vwall_never || (m_vwall_time == '1))
         && (!m_hwall_never || (m_hwall_time == '1))))
        else $error("never result with a finite time");

endmodule
